@@ src/ss_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and codes for the sortable stack.
// Used by ss_cell and sortable_stack; depends on nothing else.
package ss_pkg;

  typedef logic signed [31:0] data_t;

  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;
  localparam logic [1:0] OP_SORT = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_POP,
    CELL_SORT
  } cell_mode_e;

  typedef struct packed {
    cell_mode_e mode;
    logic       phase;
  } cell_ctrl_t;

  typedef struct packed {
    logic [1:0] op;
    data_t      value;
  } ss_in_t;

  typedef struct packed {
    data_t      popped_value;
    logic [1:0] status;
    logic [4:0] held_count;
  } ss_out_t;

endpackage

@@ src/ss_cell.sv @@
`timescale 1ns / 1ps
// One stack cell: holds a single value and trades it with its neighbors.
// Depends on ss_pkg for the control struct and data type.
module ss_cell (
  input  logic               clk_i,
  input  ss_pkg::cell_ctrl_t ctrl_i,
  input  logic               parity_i,
  input  ss_pkg::data_t      above_val_i,
  input  ss_pkg::data_t      below_val_i,
  input  logic               above_gt_i,
  input  logic               up_act_i,
  input  logic               dn_act_i,
  output ss_pkg::data_t      value_o,
  output logic               gt_o
);

  ss_pkg::data_t value_q, value_d;

  // True when this cell holds a larger value than the one below it.
  assign gt_o    = value_q > below_val_i;
  assign value_o = value_q;

  always_comb begin
    value_d = value_q;
    unique case (ctrl_i.mode)
      ss_pkg::CELL_HOLD: value_d = value_q;
      ss_pkg::CELL_PUSH: value_d = above_val_i;
      ss_pkg::CELL_POP:  value_d = below_val_i;
      ss_pkg::CELL_SORT: begin
        // Upper member of a pair keeps the smaller value, lower keeps the larger.
        if (ctrl_i.phase == parity_i) begin
          if (dn_act_i && gt_o) value_d = below_val_i;
        end else begin
          if (up_act_i && above_gt_i) value_d = above_val_i;
        end
      end
      default: value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

@@ src/sortable_stack.sv @@
`timescale 1ns / 1ps
// Top level of the sortable stack: a row of ss_cell instances plus control.
// Depends on ss_pkg and ss_cell.
//
//   Channel   Ports                       Direction  Transfer when
//   command   start, busy, cmd_i          in         start high and busy low at a rising edge
//   result    result_valid_o, result_o    out        result_valid_o high for one cycle
//
// For push, pop and the unused op code the result strobe comes in
// the cycle after the command transfer, and busy stays low, so such commands may
// follow one another in every cycle. A sort of two or more values holds busy high
// for STACK_DEPTH rounds of odd-even transposition across the cell row, one
// compare-exchange round per cycle; the result follows right after the last round.
// Reset clears the count and the control state; cell contents are left as they are.
// The receiver cannot stall, so results are never held back.
module sortable_stack #(
  parameter int STACK_DEPTH = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  ss_pkg::ss_in_t cmd_i,
  output logic           result_valid_o,
  output ss_pkg::ss_out_t result_o
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int RW = $clog2(STACK_DEPTH);
  localparam logic [RW-1:0] LAST_ROUND = RW'(STACK_DEPTH - 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SORTING = 1'b1;

  logic              state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [RW-1:0]     round_q, round_d;
  logic              out_valid_q, out_valid_d;
  ss_pkg::ss_out_t   out_q, out_d;
  ss_pkg::cell_ctrl_t ctrl;
  logic              accept;

  // Cell 0 is the top of the stack; larger indexes sit deeper.
  ss_pkg::data_t vals [STACK_DEPTH];
  logic          gts  [STACK_DEPTH];

  assign busy   = (state_q == ST_SORTING);
  assign accept = start && !busy;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    round_d     = round_q;
    out_valid_d = 1'b0;
    out_d       = out_q;
    ctrl.mode   = ss_pkg::CELL_HOLD;
    ctrl.phase  = round_q[0];

    if (state_q == ST_SORTING) begin
      ctrl.mode = ss_pkg::CELL_SORT;
      round_d   = round_q + RW'(1);
      if (round_q == LAST_ROUND) begin
        state_d            = ST_IDLE;
        out_valid_d        = 1'b1;
        out_d.popped_value = '0;
        out_d.status       = ss_pkg::ST_OK;
        out_d.held_count   = 5'(count_q);
      end
    end else if (accept) begin
      out_valid_d        = 1'b1;
      out_d.popped_value = '0;
      out_d.status       = ss_pkg::ST_OK;
      unique case (cmd_i.op)
        ss_pkg::OP_PUSH: begin
          if (count_q == CW'(STACK_DEPTH)) begin
            out_d.status = ss_pkg::ST_FULL;
          end else begin
            ctrl.mode = ss_pkg::CELL_PUSH;
            count_d   = count_q + CW'(1);
          end
        end
        ss_pkg::OP_POP: begin
          if (count_q == '0) begin
            out_d.status = ss_pkg::ST_EMPTY;
          end else begin
            ctrl.mode          = ss_pkg::CELL_POP;
            out_d.popped_value = vals[0];
            count_d            = count_q - CW'(1);
          end
        end
        ss_pkg::OP_SORT: begin
          // With fewer than two values there is nothing to reorder.
          if (count_q >= CW'(2)) begin
            state_d     = ST_SORTING;
            round_d     = '0;
            out_valid_d = 1'b0;
          end
        end
        default: ;
      endcase
      out_d.held_count = 5'(count_d);
    end
  end

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    ss_pkg::data_t above_val, below_val;
    logic          above_gt, up_act, dn_act;

    if (i == 0) begin : g_top
      assign above_val = cmd_i.value;
      assign above_gt  = 1'b0;
      assign up_act    = 1'b0;
    end else begin : g_inner_up
      assign above_val = vals[i-1];
      assign above_gt  = gts[i-1];
      assign up_act    = (CW'(i) < count_q);
    end

    if (i == STACK_DEPTH - 1) begin : g_bottom
      assign below_val = vals[i];
      assign dn_act    = 1'b0;
    end else begin : g_inner_dn
      assign below_val = vals[i+1];
      assign dn_act    = (CW'(i + 1) < count_q);
    end

    ss_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .parity_i    (1'(i % 2)),
      .above_val_i (above_val),
      .below_val_i (below_val),
      .above_gt_i  (above_gt),
      .up_act_i    (up_act),
      .dn_act_i    (dn_act),
      .value_o     (vals[i]),
      .gt_o        (gts[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      round_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      round_q     <= round_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign result_valid_o = out_valid_q;
  assign result_o       = out_q;

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for sortable_stack: push, pop, sort and the unused op code.
// Depends on ss_pkg and the sortable_stack RTL; needs no files or arguments.
module testbench;

  import ss_pkg::*;

  localparam int         STACK_DEPTH  = 16;
  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam int         RANDOM_ITEMS = 1950;
  localparam int         IDLE_PCT     = 19;
  localparam int         CALM_FIRST   = 700;
  localparam int         CALM_LAST    = 1000;
  localparam int         DRAIN_CYCLES = STACK_DEPTH + 8;
  localparam int         STALL_LIMIT  = 2000;

  logic    clk_i  = 1'b0;
  logic    rst_ni = 1'b0;
  logic    start  = 1'b0;
  ss_in_t  cmd_i  = '0;
  logic    busy;
  logic    result_valid_o;
  ss_out_t result_o;

  // Commands waiting to be driven, and results owed by the block in transfer order.
  ss_in_t  pending_cmds[$];
  ss_out_t expected_results[$];

  // Shadow copy of the stack. Cell 0 is the bottom, cell held-1 is the top.
  data_t   shadow_cells[STACK_DEPTH];
  int      shadow_held  = 0;

  int      cmds_issued  = 0;
  int      stall_cycles = 0;
  int      error_count  = 0;

  sortable_stack #(
    .STACK_DEPTH(STACK_DEPTH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .cmd_i         (cmd_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Applies one command to the shadow stack and returns the result it must produce.
  // The sort leaves the cells descending from the bottom, so the smallest is on top.
  function automatic ss_out_t apply_stack_op(ss_in_t c);
    ss_out_t r;
    data_t   tmp;
    r = '0;
    r.status = ST_OK;
    case (c.op)
      OP_PUSH: begin
        if (shadow_held >= STACK_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_cells[shadow_held] = c.value;
          shadow_held++;
        end
      end
      OP_POP: begin
        if (shadow_held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          shadow_held--;
          r.popped_value = shadow_cells[shadow_held];
        end
      end
      OP_SORT: begin
        for (int i = 1; i < shadow_held; i++) begin
          for (int j = i; j > 0 && shadow_cells[j-1] < shadow_cells[j]; j--) begin
            tmp               = shadow_cells[j];
            shadow_cells[j]   = shadow_cells[j-1];
            shadow_cells[j-1] = tmp;
          end
        end
      end
      default: begin
        // The unused op code changes nothing.
      end
    endcase
    r.held_count = shadow_held[4:0];
    return r;
  endfunction

  task automatic queue_cmd(input logic [1:0] op, input data_t value);
    ss_in_t c;
    c.op    = op;
    c.value = value;
    pending_cmds.push_back(c);
  endtask

  // Push values lean toward the extremes and toward a narrow band around zero,
  // so sorts see plenty of duplicates and sign-boundary comparisons.
  function automatic data_t pick_value();
    case ($urandom_range(9, 0))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return data_t'($urandom_range(7, 0)) - 32'sd3;
      3:       return data_t'($urandom_range(7, 0)) - 32'sd3;
      4:       return 32'sh7FFF_FFFF - data_t'($urandom_range(3, 0));
      5:       return 32'sh8000_0000 + data_t'($urandom_range(3, 0));
      default: return data_t'($urandom());
    endcase
  endfunction

  // Driver: presents one command at a time and holds it until a transfer
  // happens, that is a rising edge with start high and busy low. Between
  // commands it idles at random, except for a calm stretch in the middle.
  // Each transfer feeds the shadow model right away, so the expectation is
  // queued before its result strobe can arrive.
  always @(posedge clk_i) begin : cmd_driver
    logic   taken;
    logic   next_start;
    ss_in_t next_cmd;
    taken      = rst_ni && start && !busy;
    next_start = start;
    next_cmd   = cmd_i;
    if (taken) begin
      expected_results.push_back(apply_stack_op(cmd_i));
      next_start = 1'b0;
    end
    if (rst_ni && !next_start && pending_cmds.size() > 0) begin
      if ((cmds_issued >= CALM_FIRST && cmds_issued < CALM_LAST) ||
          $urandom_range(99, 0) >= IDLE_PCT) begin
        next_cmd   = pending_cmds.pop_front();
        next_start = 1'b1;
        cmds_issued++;
      end
    end
    start <= next_start;
    cmd_i <= next_cmd;
  end

  // Monitor: the result strobe lasts one cycle and cannot be held off, so
  // every strobe is checked against the oldest expectation at once.
  always @(posedge clk_i) begin : result_monitor
    ss_out_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, got popped_value %0d status %0d held_count %0d",
                 $time, result_o.popped_value, result_o.status, result_o.held_count);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (result_o.popped_value !== want.popped_value) begin
          $display("%0t: popped_value expected %0d, got %0d",
                   $time, want.popped_value, result_o.popped_value);
          error_count++;
        end
        if (result_o.status !== want.status) begin
          $display("%0t: status expected %0d, got %0d", $time, want.status, result_o.status);
          error_count++;
        end
        if (result_o.held_count !== want.held_count) begin
          $display("%0t: held_count expected %0d, got %0d",
                   $time, want.held_count, result_o.held_count);
          error_count++;
        end
      end
    end
  end

  // Cycles with neither a command transfer nor a result count toward the limit.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (stall_cycles >= STALL_LIMIT);
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    int    kind;
    int    burst;
    int    push_pct;
    int    pop_pct;
    int    roll;
    data_t fill_values[STACK_DEPTH];

    // Directed part: empty-stack corner cases, a one-value sort, then a full
    // stack built from extreme and duplicate values, an overflow and a sort.
    queue_cmd(OP_POP, 32'sd0);
    queue_cmd(OP_SORT, 32'sd0);
    queue_cmd(OP_UNUSED, 32'sh5A5A_5A5A);
    queue_cmd(OP_PUSH, 32'sh7FFF_FFFF);
    queue_cmd(OP_SORT, 32'sd0);
    queue_cmd(OP_POP, 32'shFFFF_FFFF);
    fill_values = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd0, -32'sd1, 32'sd1,
                    32'sh5555_5555, 32'shAAAA_AAAA, 32'sh7FFF_FFFF, 32'sh8000_0000,
                    32'sd1, 32'sd0, -32'sd2, 32'sh0000_FFFF, 32'shFFFF_0000,
                    32'sd0, 32'sd0};
    fill_values[14] = data_t'($urandom());
    fill_values[15] = data_t'($urandom());
    foreach (fill_values[i]) queue_cmd(OP_PUSH, fill_values[i]);
    queue_cmd(OP_PUSH, 32'sh1234_5678);
    queue_cmd(OP_SORT, 32'sd0);
    queue_cmd(OP_UNUSED, 32'sd0);

    // Random part: bursts that lean toward filling, draining or neither, so
    // the fill level wanders over the whole range and both limits get hit.
    while (pending_cmds.size() < RANDOM_ITEMS + 25) begin
      kind  = $urandom_range(2, 0);
      burst = $urandom_range(40, 10);
      case (kind)
        0:       begin push_pct = 70; pop_pct = 20; end
        1:       begin push_pct = 20; pop_pct = 70; end
        default: begin push_pct = 45; pop_pct = 45; end
      endcase
      repeat (burst) begin
        roll = $urandom_range(99, 0);
        if (roll < push_pct) begin
          queue_cmd(OP_PUSH, pick_value());
        end else if (roll < push_pct + pop_pct) begin
          queue_cmd(OP_POP, data_t'($urandom()));
        end else if (roll < 98) begin
          queue_cmd(OP_SORT, data_t'($urandom()));
        end else begin
          queue_cmd(OP_UNUSED, data_t'($urandom()));
        end
      end
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_cmds.size() != 0 || start || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
